FILE: sv/yrc_pkg.sv
// Shared types and constants for the YCbCr 4:2:2 / 4:4:4 to RGB converter.
// Holds filter and matrix coefficients, stage payload structs and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package yrc_pkg;

   localparam int FILTER_TAPS = 12;
   localparam int HALF_TAPS   = FILTER_TAPS / 2;
   localparam int CENTRE      = HALF_TAPS - 1;
   localparam int LAG         = HALF_TAPS;
   localparam int TAP_IDX_W   = $clog2(FILTER_TAPS);
   localparam int PEND_W      = $clog2(LAG + 1);
   localparam int CSR_INDEX_W = 2;
   localparam int FIR_W       = 27;
   localparam int MAT_W       = 27;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATRIX_SELECT = 2'd0,
      CSR_FILTER_SELECT = 2'd1,
      CSR_CHROMA_FULL   = 2'd2
   } csr_index_type;

   typedef logic [7:0]                   sample_type;
   typedef logic signed [17:0]           coef_type;
   typedef sample_type [FILTER_TAPS-1:0] window_type;
   typedef logic [15:0]                  luma_pair_type;

   // Half-band taps 0..5; taps 6..11 mirror them.
   localparam coef_type HALF_BAND [HALF_TAPS] = '{
      -18'sd382, 18'sd1331, -18'sd2930, 18'sd5889, -18'sd12303, 18'sd41163
   };

   localparam coef_type REC601_V_TO_R = 18'sd89831;
   localparam coef_type REC601_V_TO_G = 18'sd45757;
   localparam coef_type REC601_U_TO_G = 18'sd22050;
   localparam coef_type REC601_U_TO_B = 18'sd113538;
   localparam coef_type REC709_V_TO_R = 18'sd100902;
   localparam coef_type REC709_V_TO_G = 18'sd29994;
   localparam coef_type REC709_U_TO_G = 18'sd12002;
   localparam coef_type REC709_U_TO_B = 18'sd118894;

   typedef struct packed {
      sample_type luma_first;
      sample_type luma_second;
      sample_type cb_first;
      sample_type cr_first;
      sample_type cb_second;
      sample_type cr_second;
      logic       line_end;
   } pair_in_type;

   typedef struct packed {
      window_type cb_taps;
      window_type cr_taps;
      sample_type luma_even;
      sample_type luma_odd;
      sample_type cb_odd;
      sample_type cr_odd;
      logic       direct;
      logic       line_done;
   } taps_type;

   typedef struct packed {
      sample_type luma_even;
      sample_type luma_odd;
      sample_type cb_even;
      sample_type cr_even;
      sample_type cb_odd;
      sample_type cr_odd;
      logic       line_done;
   } pixel_pair_type;

   typedef struct packed {
      sample_type red_first;
      sample_type green_first;
      sample_type blue_first;
      sample_type red_second;
      sample_type green_second;
      sample_type blue_second;
      logic       line_done;
   } rgb_pair_type;

endpackage

`default_nettype wire

FILE: sv/yrc_if.sv
// Channel interfaces of the converter: pixel pair input, RGB result, register write.
// Each carries valid, ready and its payload. Depends on yrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface yrc_req_if;
   import yrc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type luma_first;
   sample_type luma_second;
   sample_type cb_first;
   sample_type cr_first;
   sample_type cb_second;
   sample_type cr_second;
   logic       line_end;

   modport source (output valid, luma_first, luma_second, cb_first, cr_first,
                   cb_second, cr_second, line_end, input ready);
   modport sink   (input valid, luma_first, luma_second, cb_first, cr_first,
                   cb_second, cr_second, line_end, output ready);
endinterface

interface yrc_rsp_if;
   import yrc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type red_first;
   sample_type green_first;
   sample_type blue_first;
   sample_type red_second;
   sample_type green_second;
   sample_type blue_second;
   logic       line_done;

   modport source (output valid, red_first, green_first, blue_first, red_second,
                   green_second, blue_second, line_done, input ready);
   modport sink   (input valid, red_first, green_first, blue_first, red_second,
                   green_second, blue_second, line_done, output ready);
endinterface

interface yrc_csr_if;
   import yrc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic                   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/yrc_window.sv
// Chroma line window and luma delay for 4:2:2 upsampling, plus end-of-line flush.
// Emits one tap snapshot per result into a registered stage. Depends on yrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yrc_window (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   chroma_full,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  yrc_pkg::pair_in_type   in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output yrc_pkg::taps_type      out_data
);
   import yrc_pkg::*;

   window_type                cbw_ff, cbw_in, crw_ff, crw_in;
   window_type                cb_ins, cr_ins;
   luma_pair_type [LAG:0]     luma_ff, luma_in, luma_ins;
   logic [PEND_W-1:0]         pend_ff, pend_in, flush_ff, flush_in, idx;
   logic                      in_line_ff, in_line_in;
   logic                      snap_v_ff, snap_v_in;
   taps_type                  snap_ff, snap_in;
   logic [TAP_IDX_W-1:0]      ins_pos;
   logic                      snap_free, flushing, accept;

   function automatic window_type shift_window(window_type w, sample_type fill);
      return {fill, w[FILTER_TAPS-1:1]};
   endfunction

   function automatic luma_pair_type [LAG:0] shift_luma(luma_pair_type [LAG:0] l);
      return {l[LAG], l[LAG:1]};
   endfunction

   function automatic taps_type make_snap(window_type cb, window_type cr,
                                          luma_pair_type y, logic done);
      taps_type t;
      t.cb_taps   = cb;
      t.cr_taps   = cr;
      t.luma_even = y[15:8];
      t.luma_odd  = y[7:0];
      t.cb_odd    = cb[CENTRE];
      t.cr_odd    = cr[CENTRE];
      t.direct    = 1'b0;
      t.line_done = done;
      return t;
   endfunction

   assign snap_free = !snap_v_ff || out_ready;
   assign flushing  = flush_ff != '0;
   assign in_ready  = !flushing && snap_free;
   assign accept    = in_valid && in_ready;
   assign idx       = in_line_ff ? pend_ff : '0;
   assign ins_pos   = TAP_IDX_W'(CENTRE) + TAP_IDX_W'(idx);

   // Window after writing this item's chroma (line start refills it first).
   always_comb begin
      luma_ins      = luma_ff;
      luma_ins[idx] = {in_data.luma_first, in_data.luma_second};
      for (int k = 0; k < FILTER_TAPS; k++) begin
         cb_ins[k] = in_line_ff ? cbw_ff[k] : in_data.cb_first;
         cr_ins[k] = in_line_ff ? crw_ff[k] : in_data.cr_first;
         if (TAP_IDX_W'(k) == ins_pos ||
             (in_data.line_end && TAP_IDX_W'(k) > ins_pos)) begin
            cb_ins[k] = in_data.cb_first;
            cr_ins[k] = in_data.cr_first;
         end
      end
   end

   always_comb begin
      cbw_in     = cbw_ff;
      crw_in     = crw_ff;
      luma_in    = luma_ff;
      pend_in    = pend_ff;
      in_line_in = in_line_ff;
      flush_in   = flush_ff;
      snap_v_in  = snap_v_ff && !out_ready;
      snap_in    = snap_ff;
      if (flushing) begin
         if (snap_free) begin
            // advance through the rest of the line, padding with the last chroma
            snap_v_in = 1'b1;
            snap_in   = make_snap(cbw_ff, crw_ff, luma_ff[0], flush_ff == PEND_W'(1));
            cbw_in    = shift_window(cbw_ff, cbw_ff[FILTER_TAPS-1]);
            crw_in    = shift_window(crw_ff, crw_ff[FILTER_TAPS-1]);
            luma_in   = shift_luma(luma_ff);
            flush_in  = flush_ff - PEND_W'(1);
         end
      end else if (accept) begin
         if (chroma_full) begin
            snap_v_in         = 1'b1;
            snap_in.cb_taps   = {FILTER_TAPS{in_data.cb_first}};
            snap_in.cr_taps   = {FILTER_TAPS{in_data.cr_first}};
            snap_in.luma_even = in_data.luma_first;
            snap_in.luma_odd  = in_data.luma_second;
            snap_in.cb_odd    = in_data.cb_second;
            snap_in.cr_odd    = in_data.cr_second;
            snap_in.direct    = 1'b1;
            snap_in.line_done = in_data.line_end;
            pend_in           = '0;
            in_line_in        = 1'b0;
         end else if (in_data.line_end) begin
            snap_v_in  = 1'b1;
            snap_in    = make_snap(cb_ins, cr_ins, luma_ins[0], idx == '0);
            cbw_in     = shift_window(cb_ins, in_data.cb_first);
            crw_in     = shift_window(cr_ins, in_data.cr_first);
            luma_in    = shift_luma(luma_ins);
            flush_in   = idx;
            pend_in    = '0;
            in_line_in = 1'b0;
         end else if (idx == PEND_W'(LAG)) begin
            snap_v_in  = 1'b1;
            snap_in    = make_snap(cb_ins, cr_ins, luma_ins[0], 1'b0);
            cbw_in     = shift_window(cb_ins, in_data.cb_first);
            crw_in     = shift_window(cr_ins, in_data.cr_first);
            luma_in    = shift_luma(luma_ins);
            pend_in    = PEND_W'(LAG);
            in_line_in = 1'b1;
         end else begin
            cbw_in     = cb_ins;
            crw_in     = cr_ins;
            luma_in    = luma_ins;
            pend_in    = idx + PEND_W'(1);
            in_line_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         in_line_ff <= 1'b0;
         flush_ff   <= '0;
         snap_v_ff  <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         in_line_ff <= in_line_in;
         flush_ff   <= flush_in;
         snap_v_ff  <= snap_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cbw_ff  <= cbw_in;
      crw_ff  <= crw_in;
      luma_ff <= luma_in;
      snap_ff <= snap_in;
   end

   assign out_valid = snap_v_ff;
   assign out_data  = snap_ff;

`ifndef SYNTHESIS
   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      flushing |-> !in_ready)
      else $error("input taken during end-of-line flush");

   a_full_closes_line: assert property (@(posedge clock) disable iff (reset)
      (accept && chroma_full) |=> (pend_ff == '0 && !in_line_ff && flush_ff == '0))
      else $error("4:4:4 transfer left 4:2:2 state open");

   a_flush_steps: assert property (@(posedge clock) disable iff (reset)
      (flushing && snap_free) |=> (out_valid && flush_ff == $past(flush_ff) - PEND_W'(1)))
      else $error("flush count did not advance with an emitted pair");

   a_closed_line_empty: assert property (@(posedge clock) disable iff (reset)
      !in_line_ff |-> (pend_ff == '0))
      else $error("pending pairs outside an open line");
`endif

endmodule

`default_nettype wire

FILE: sv/yrc_chroma.sv
// Odd-pixel chroma interpolation: rounded average or 12-tap half-band filter.
// Two registered stages (tap products, then sum and clamp). Depends on yrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yrc_chroma (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   filter_select,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  yrc_pkg::taps_type      in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output yrc_pkg::pixel_pair_type out_data
);
   import yrc_pkg::*;

   typedef logic signed [FIR_W-1:0] fir_type;

   typedef struct packed {
      fir_type [HALF_TAPS-1:0] cb_prod;
      fir_type [HALF_TAPS-1:0] cr_prod;
      sample_type              cb_alt;
      sample_type              cr_alt;
      logic                    use_fir;
      sample_type              luma_even;
      sample_type              luma_odd;
      sample_type              cb_even;
      sample_type              cr_even;
      logic                    line_done;
   } fir_prod_type;

   logic           prod_v_ff, prod_v_in, out_v_ff, out_v_in;
   fir_prod_type   prod_ff, prod_in;
   pixel_pair_type out_ff, out_in;
   logic           prod_free, out_free;

   function automatic sample_type clamp_fir(fir_type [HALF_TAPS-1:0] p);
      fir_type acc;
      acc = '0;
      for (int j = 0; j < HALF_TAPS; j++) begin
         acc = acc + $signed(p[j]);
      end
      if (acc[FIR_W-1]) begin
         return 8'd0;
      end else if (|acc[FIR_W-2:24]) begin
         return 8'd255;
      end else begin
         return acc[23:16];
      end
   endfunction

   assign out_free  = !out_v_ff || out_ready;
   assign prod_free = !prod_v_ff || out_free;
   assign in_ready  = prod_free;

   // Stage 1: fold the symmetric taps and multiply.
   always_comb begin
      logic [8:0] cb_pair, cr_pair, cb_avg, cr_avg;
      prod_in = prod_ff;
      for (int j = 0; j < HALF_TAPS; j++) begin
         cb_pair = 9'(in_data.cb_taps[j]) + 9'(in_data.cb_taps[FILTER_TAPS-1-j]);
         cr_pair = 9'(in_data.cr_taps[j]) + 9'(in_data.cr_taps[FILTER_TAPS-1-j]);
         prod_in.cb_prod[j] = fir_type'($signed({1'b0, cb_pair})) * fir_type'(HALF_BAND[j]);
         prod_in.cr_prod[j] = fir_type'($signed({1'b0, cr_pair})) * fir_type'(HALF_BAND[j]);
      end
      cb_avg = 9'(in_data.cb_taps[CENTRE]) + 9'(in_data.cb_taps[CENTRE+1]) + 9'd1;
      cr_avg = 9'(in_data.cr_taps[CENTRE]) + 9'(in_data.cr_taps[CENTRE+1]) + 9'd1;
      prod_in.cb_alt    = in_data.direct ? in_data.cb_odd : cb_avg[8:1];
      prod_in.cr_alt    = in_data.direct ? in_data.cr_odd : cr_avg[8:1];
      prod_in.use_fir   = filter_select && !in_data.direct;
      prod_in.luma_even = in_data.luma_even;
      prod_in.luma_odd  = in_data.luma_odd;
      prod_in.cb_even   = in_data.cb_taps[CENTRE];
      prod_in.cr_even   = in_data.cr_taps[CENTRE];
      prod_in.line_done = in_data.line_done;
   end

   // Stage 2: sum, truncate and clamp, then pick the odd-pixel chroma.
   always_comb begin
      out_in.luma_even = prod_ff.luma_even;
      out_in.luma_odd  = prod_ff.luma_odd;
      out_in.cb_even   = prod_ff.cb_even;
      out_in.cr_even   = prod_ff.cr_even;
      out_in.cb_odd    = prod_ff.use_fir ? clamp_fir(prod_ff.cb_prod) : prod_ff.cb_alt;
      out_in.cr_odd    = prod_ff.use_fir ? clamp_fir(prod_ff.cr_prod) : prod_ff.cr_alt;
      out_in.line_done = prod_ff.line_done;
   end

   assign prod_v_in = prod_free ? in_valid : prod_v_ff;
   assign out_v_in  = out_free ? prod_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         prod_v_ff <= prod_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && prod_free) begin
         prod_ff <= prod_in;
      end
      if (prod_v_ff && out_free) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

FILE: sv/yrc_matrix.sv
// YCbCr to RGB matrix for a pixel pair, Rec601 or Rec709 coefficients in signed Q2.16 (18 bits).
// Two registered stages (products, then quotient, add and clamp). Depends on yrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yrc_matrix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    matrix_select,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  yrc_pkg::pixel_pair_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output yrc_pkg::rgb_pair_type   out_data
);
   import yrc_pkg::*;

   typedef logic signed [MAT_W-1:0] mat_type;

   typedef struct packed {
      mat_type    vr;
      mat_type    vg;
      mat_type    ug;
      mat_type    ub;
      sample_type luma;
   } pix_prod_type;

   typedef struct packed {
      pix_prod_type even;
      pix_prod_type odd;
      logic         line_done;
   } mat_prod_type;

   logic         prod_v_ff, prod_v_in, out_v_ff, out_v_in;
   mat_prod_type prod_ff, prod_in;
   rgb_pair_type out_ff, out_in;
   logic         prod_free, out_free;
   coef_type     k_vr, k_vg, k_ug, k_ub;

   function automatic pix_prod_type products(sample_type y, sample_type cb, sample_type cr,
                                             coef_type vr, coef_type vg,
                                             coef_type ug, coef_type ub);
      logic signed [8:0] u, v;
      pix_prod_type      p;
      u      = $signed({1'b0, cb}) - 9'sd128;
      v      = $signed({1'b0, cr}) - 9'sd128;
      p.vr   = mat_type'(v) * mat_type'(vr);
      p.vg   = mat_type'(v) * mat_type'(vg);
      p.ug   = mat_type'(u) * mat_type'(ug);
      p.ub   = mat_type'(u) * mat_type'(ub);
      p.luma = y;
      return p;
   endfunction

   // Divide by 65536, rounding toward zero.
   function automatic logic signed [10:0] quot16(mat_type p);
      mat_type adj;
      adj = p + $signed({{(MAT_W-16){1'b0}}, {16{p[MAT_W-1]}}});
      return 11'(adj >>> 16);
   endfunction

   function automatic sample_type clamp8(logic signed [11:0] s);
      if (s[11]) begin
         return 8'd0;
      end else if (|s[10:8]) begin
         return 8'd255;
      end else begin
         return s[7:0];
      end
   endfunction

   function automatic logic [23:0] to_rgb(pix_prod_type p);
      logic signed [11:0] y, r, g, b;
      y = $signed({4'b0000, p.luma});
      r = y + 12'(quot16(p.vr));
      g = y - 12'(quot16(p.vg + p.ug));
      b = y + 12'(quot16(p.ub));
      return {clamp8(r), clamp8(g), clamp8(b)};
   endfunction

   assign k_vr = matrix_select ? REC709_V_TO_R : REC601_V_TO_R;
   assign k_vg = matrix_select ? REC709_V_TO_G : REC601_V_TO_G;
   assign k_ug = matrix_select ? REC709_U_TO_G : REC601_U_TO_G;
   assign k_ub = matrix_select ? REC709_U_TO_B : REC601_U_TO_B;

   assign out_free  = !out_v_ff || out_ready;
   assign prod_free = !prod_v_ff || out_free;
   assign in_ready  = prod_free;

   always_comb begin
      prod_in.even = products(in_data.luma_even, in_data.cb_even, in_data.cr_even,
                              k_vr, k_vg, k_ug, k_ub);
      prod_in.odd  = products(in_data.luma_odd, in_data.cb_odd, in_data.cr_odd,
                              k_vr, k_vg, k_ug, k_ub);
      prod_in.line_done = in_data.line_done;
   end

   always_comb begin
      {out_in.red_first, out_in.green_first, out_in.blue_first}    = to_rgb(prod_ff.even);
      {out_in.red_second, out_in.green_second, out_in.blue_second} = to_rgb(prod_ff.odd);
      out_in.line_done = prod_ff.line_done;
   end

   assign prod_v_in = prod_free ? in_valid : prod_v_ff;
   assign out_v_in  = out_free ? prod_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         prod_v_ff <= prod_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && prod_free) begin
         prod_ff <= prod_in;
      end
      if (prod_v_ff && out_free) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

FILE: sv/yuv422_to_rgb_converter.sv
// Top level of the YCbCr to RGB converter: control registers and the pipeline.
// Uses yrc_pkg, yrc_if, yrc_window, yrc_chroma and yrc_matrix.
//
//   channel    direction   payload                                   transfer
//   req_chan   in          two luma, two Cb/Cr pairs, line_end       valid & ready
//   rsp_chan   out         RGB of even and odd pixel, line_done      valid & ready
//   csr_chan   in          register index, one data bit              valid & ready
//
// One pixel pair is taken per cycle while req_chan ready is high; a result passes through
// the window snapshot, two chroma stages and two matrix stages after the transfer that completes it.
// In 4:2:2 mode a pair's result waits for the six pairs after it; a line_end pair
// holds req_chan ready low while the pairs still waiting (up to 6) are flushed out.
// Synchronous reset clears the registers and empties the pipeline and window.
// Stalls on rsp_chan back up stage by stage; each stage refills as soon as it moves.
`timescale 1ns / 1ps
`default_nettype none

module yuv422_to_rgb_converter (
   input  logic      clock,
   input  logic      reset,
   yrc_csr_if.sink   csr_chan,
   yrc_req_if.sink   req_chan,
   yrc_rsp_if.source rsp_chan
);
   import yrc_pkg::*;

   logic           matrix_ff, matrix_in, filter_ff, filter_in, full_ff, full_in;
   pair_in_type    req_data;
   taps_type       taps;
   pixel_pair_type pixels;
   rgb_pair_type   rgb;
   logic           taps_valid, taps_ready, pix_valid, pix_ready;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      matrix_in = matrix_ff;
      filter_in = filter_ff;
      full_in   = full_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_MATRIX_SELECT: matrix_in = csr_chan.data;
            CSR_FILTER_SELECT: filter_in = csr_chan.data;
            CSR_CHROMA_FULL:   full_in   = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= 1'b0;
         filter_ff <= 1'b0;
         full_ff   <= 1'b0;
      end else begin
         matrix_ff <= matrix_in;
         filter_ff <= filter_in;
         full_ff   <= full_in;
      end
   end

   assign req_data.luma_first  = req_chan.luma_first;
   assign req_data.luma_second = req_chan.luma_second;
   assign req_data.cb_first    = req_chan.cb_first;
   assign req_data.cr_first    = req_chan.cr_first;
   assign req_data.cb_second   = req_chan.cb_second;
   assign req_data.cr_second   = req_chan.cr_second;
   assign req_data.line_end    = req_chan.line_end;

   yrc_window u_window (
      .clock       (clock),
      .reset       (reset),
      .chroma_full (full_ff),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_data     (req_data),
      .out_valid   (taps_valid),
      .out_ready   (taps_ready),
      .out_data    (taps)
   );

   yrc_chroma u_chroma (
      .clock         (clock),
      .reset         (reset),
      .filter_select (filter_ff),
      .in_valid      (taps_valid),
      .in_ready      (taps_ready),
      .in_data       (taps),
      .out_valid     (pix_valid),
      .out_ready     (pix_ready),
      .out_data      (pixels)
   );

   yrc_matrix u_matrix (
      .clock         (clock),
      .reset         (reset),
      .matrix_select (matrix_ff),
      .in_valid      (pix_valid),
      .in_ready      (pix_ready),
      .in_data       (pixels),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_data      (rgb)
   );

   assign rsp_chan.red_first    = rgb.red_first;
   assign rsp_chan.green_first  = rgb.green_first;
   assign rsp_chan.blue_first   = rgb.blue_first;
   assign rsp_chan.red_second   = rgb.red_second;
   assign rsp_chan.green_second = rgb.green_second;
   assign rsp_chan.blue_second  = rgb.blue_second;
   assign rsp_chan.line_done    = rgb.line_done;

endmodule

`default_nettype wire
